// ----- hw/rtl/chdec_pkg.sv -----
// Shared types, byte constants and a hex digit helper for the chunked body decoder.
package chdec_pkg;

	localparam int SIZE_DIGITS_DEF = 8;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HI = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [3:0] HEX_TEN  = 4'ha;

	typedef enum logic [2:0] {
		PH_SIZE  = 3'd0,
		PH_EXT   = 3'd1,
		PH_LF    = 3'd2,
		PH_DATA  = 3'd3,
		PH_TRAIL = 3'd4,
		PH_ENDLF = 3'd5,
		PH_DONE  = 3'd6,
		PH_ERR   = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		K_FRAME  = 3'd0,
		K_BODY   = 3'd1,
		K_END    = 3'd2,
		K_ERROR  = 3'd3,
		K_IGNORE = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] body_byte;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.value = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			h.value = 4'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LF_HI) begin
			h.value = 4'(c - CH_LA) + HEX_TEN;
		end else if (c >= CH_UA && c <= CH_UF) begin
			h.value = 4'(c - CH_UA) + HEX_TEN;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ----- hw/rtl/chdec_if.sv -----
// Valid/ready channel interfaces for the input bytes and the decoded results.
interface chdec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_req;

	modport source (output valid, output data_byte, output start_req, input ready);
	modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface chdec_out_if;
	logic                valid;
	logic                ready;
	chdec_pkg::kind_t    kind;
	logic [7:0]          body_byte;

	modport source (output valid, output kind, output body_byte, input ready);
	modport sink (input valid, input kind, input body_byte, output ready);
endinterface

// ----- hw/rtl/chdec_step.sv -----
// Next-state and result logic for one byte of the chunked body parser.
module chdec_step #(
	parameter int SIZE_DIGITS = chdec_pkg::SIZE_DIGITS_DEF
) (
	input  chdec_pkg::phase_t                     phase,
	input  logic [4*SIZE_DIGITS-1:0]              chunk,
	input  logic [$clog2(SIZE_DIGITS+1)-1:0]      dcnt,
	input  logic [1:0]                            skip,
	input  logic [7:0]                            data_byte,
	input  logic                                  start_req,
	output chdec_pkg::phase_t                     phase_nx,
	output logic [4*SIZE_DIGITS-1:0]              chunk_nx,
	output logic [$clog2(SIZE_DIGITS+1)-1:0]      dcnt_nx,
	output logic [1:0]                            skip_nx,
	output chdec_pkg::result_t                    result
);
	localparam int CW = 4 * SIZE_DIGITS;
	localparam int DW = $clog2(SIZE_DIGITS + 1);

	chdec_pkg::phase_t    ph;
	logic [CW-1:0]        ch;
	logic [DW-1:0]        dc;
	logic [1:0]           sk;
	logic [CW-1:0]        ch_dec;
	chdec_pkg::hex_t      hx;

	always_comb begin
		ph = start_req ? chdec_pkg::PH_SIZE : phase;
		ch = start_req ? '0 : chunk;
		dc = start_req ? '0 : dcnt;
		sk = start_req ? 2'd0 : skip;
		hx = chdec_pkg::hex_decode(data_byte);
		ch_dec = ch - CW'(1);

		phase_nx = ph;
		chunk_nx = ch;
		dcnt_nx = dc;
		skip_nx = sk;
		result.kind = chdec_pkg::K_FRAME;
		result.body_byte = 8'd0;

		unique case (ph)
			chdec_pkg::PH_SIZE, chdec_pkg::PH_EXT: begin
				if (data_byte == chdec_pkg::CH_CR) begin
					if (dc == '0) begin
						phase_nx = chdec_pkg::PH_ERR;
						result.kind = chdec_pkg::K_ERROR;
					end else begin
						phase_nx = (ch == '0) ? chdec_pkg::PH_ENDLF : chdec_pkg::PH_LF;
					end
				end else if (data_byte == chdec_pkg::CH_SEMI) begin
					if (ph == chdec_pkg::PH_EXT || dc == '0) begin
						phase_nx = chdec_pkg::PH_ERR;
						result.kind = chdec_pkg::K_ERROR;
					end else begin
						phase_nx = chdec_pkg::PH_EXT;
					end
				end else if (ph == chdec_pkg::PH_SIZE) begin
					if (!hx.ok || dc >= DW'(SIZE_DIGITS)) begin
						phase_nx = chdec_pkg::PH_ERR;
						result.kind = chdec_pkg::K_ERROR;
					end else begin
						chunk_nx = (ch << 4) | CW'(hx.value);
						dcnt_nx = dc + DW'(1);
					end
				end
			end
			chdec_pkg::PH_LF: begin
				phase_nx = chdec_pkg::PH_DATA;
			end
			chdec_pkg::PH_DATA: begin
				result.kind = chdec_pkg::K_BODY;
				result.body_byte = data_byte;
				chunk_nx = ch_dec;
				if (ch_dec == '0) begin
					phase_nx = chdec_pkg::PH_TRAIL;
					skip_nx = 2'd2;
				end
			end
			chdec_pkg::PH_TRAIL: begin
				skip_nx = sk - 2'd1;
				if (sk == 2'd1) begin
					phase_nx = chdec_pkg::PH_SIZE;
					chunk_nx = '0;
					dcnt_nx = '0;
					skip_nx = 2'd0;
				end
			end
			chdec_pkg::PH_ENDLF: begin
				phase_nx = chdec_pkg::PH_DONE;
				result.kind = chdec_pkg::K_END;
			end
			chdec_pkg::PH_DONE, chdec_pkg::PH_ERR: begin
				result.kind = chdec_pkg::K_IGNORE;
			end
			default: begin
				result.kind = chdec_pkg::K_IGNORE;
			end
		endcase
	end
endmodule

// ----- hw/rtl/http_chunked_body_decoder_top.sv -----
// Top level of the chunked body decoder: parse state and result register.
//
//   channel   direction   payload                       word
//   in_ch     sink        data_byte[7:0], start_req     one body byte
//   out_ch    source      kind[2:0], body_byte[7:0]     one result per byte
//
// Each accepted word is parsed in the cycle it arrives, and its result appears
// in the output register in the next cycle. One word is accepted per cycle
// unless stalled: the input stalls only while the output is full and not taken.
// Reset returns the parser to the start of a size line with a zero count.
module http_chunked_body_decoder_top #(
	parameter int SIZE_DIGITS = chdec_pkg::SIZE_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	chdec_in_if.sink    in_ch,
	chdec_out_if.source out_ch
);
	localparam int CW = 4 * SIZE_DIGITS;
	localparam int DW = $clog2(SIZE_DIGITS + 1);

	chdec_pkg::phase_t   phase_q, phase_nx;
	logic [CW-1:0]       chunk_q, chunk_nx;
	logic [DW-1:0]       dcnt_q, dcnt_nx;
	logic [1:0]          skip_q, skip_nx;
	chdec_pkg::result_t  result, result_q;
	logic                out_valid_q;
	logic                in_acc;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc = in_ch.valid && in_ch.ready;

	chdec_step #(.SIZE_DIGITS(SIZE_DIGITS)) u_step (
		.phase     (phase_q),
		.chunk     (chunk_q),
		.dcnt      (dcnt_q),
		.skip      (skip_q),
		.data_byte (in_ch.data_byte),
		.start_req (in_ch.start_req),
		.phase_nx  (phase_nx),
		.chunk_nx  (chunk_nx),
		.dcnt_nx   (dcnt_nx),
		.skip_nx   (skip_nx),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= chdec_pkg::PH_SIZE;
			chunk_q <= '0;
			dcnt_q <= '0;
			skip_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q <= phase_nx;
				chunk_q <= chunk_nx;
				dcnt_q <= dcnt_nx;
				skip_q <= skip_nx;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_q <= result;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = result_q.kind;
	assign out_ch.body_byte = result_q.body_byte;

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == chdec_pkg::PH_DATA |-> chunk_q != '0)
		else $error("Data phase entered with no bytes due.");

	a_data_body: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_ch.start_req && phase_q == chdec_pkg::PH_DATA)
		|=> (out_ch.kind == chdec_pkg::K_BODY && out_ch.body_byte == $past(in_ch.data_byte)))
		else $error("Data phase byte not passed out as a body byte.");

	a_done_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_ch.start_req &&
			(phase_q == chdec_pkg::PH_DONE || phase_q == chdec_pkg::PH_ERR))
		|=> (out_ch.kind == chdec_pkg::K_IGNORE && phase_q == $past(phase_q)))
		else $error("Byte after end or error not ignored.");

	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= DW'(SIZE_DIGITS))
		else $error("Digit count beyond the size limit.");
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the HTTP chunked body decoder top level.
`timescale 1ns / 1ps

module tb;
	localparam int          SD           = chdec_pkg::SIZE_DIGITS_DEF;
	localparam int unsigned ITEMS        = 1750;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam logic [7:0]  LF_BYTE      = 8'h0a;

	class chunk_decode_model;
		chdec_pkg::phase_t  phase;
		logic [4*SD-1:0]    remaining;
		logic [3:0]         digits;
		logic               ext_seen;
		logic [1:0]         skip;
		chdec_pkg::result_t due_results[$];
		int unsigned        failures;
		int unsigned        checked;
		int unsigned        n_body;
		int unsigned        n_end;
		int unsigned        n_err;
		int unsigned        n_ignore;

		function new();
			phase = chdec_pkg::PH_SIZE;
			clear_line();
			failures = 0;
			checked = 0;
			n_body = 0;
			n_end = 0;
			n_err = 0;
			n_ignore = 0;
		endfunction

		function void clear_line();
			remaining = '0;
			digits = '0;
			ext_seen = 1'b0;
			skip = '0;
		endfunction

		function int digit_value(logic [7:0] c);
			if (c >= "0" && c <= "9") begin
				return int'(c) - int'("0");
			end
			if (c >= "a" && c <= "f") begin
				return int'(c) - int'("a") + 10;
			end
			if (c >= "A" && c <= "F") begin
				return int'(c) - int'("A") + 10;
			end
			return -1;
		endfunction

		function chdec_pkg::kind_t close_line();
			if (digits == 0) begin
				phase = chdec_pkg::PH_ERR;
				return chdec_pkg::K_ERROR;
			end
			phase = (remaining == 0) ? chdec_pkg::PH_ENDLF : chdec_pkg::PH_LF;
			return chdec_pkg::K_FRAME;
		endfunction

		function void note_byte(logic [7:0] c, logic s);
			chdec_pkg::result_t r;
			int                 v;
			r.kind = chdec_pkg::K_FRAME;
			r.body_byte = 8'h00;
			if (s) begin
				phase = chdec_pkg::PH_SIZE;
				clear_line();
			end
			case (phase)
				chdec_pkg::PH_SIZE: begin
					if (c == chdec_pkg::CH_SEMI) begin
						if (digits == 0) begin
							phase = chdec_pkg::PH_ERR;
							r.kind = chdec_pkg::K_ERROR;
						end else begin
							ext_seen = 1'b1;
							phase = chdec_pkg::PH_EXT;
						end
					end else if (c == chdec_pkg::CH_CR) begin
						r.kind = close_line();
					end else begin
						v = digit_value(c);
						if (v < 0 || digits >= SD) begin
							phase = chdec_pkg::PH_ERR;
							r.kind = chdec_pkg::K_ERROR;
						end else begin
							remaining = {remaining[4*SD-5:0], 4'(v)};
							digits++;
						end
					end
				end
				chdec_pkg::PH_EXT: begin
					if (c == chdec_pkg::CH_SEMI) begin
						phase = chdec_pkg::PH_ERR;
						r.kind = chdec_pkg::K_ERROR;
					end else if (c == chdec_pkg::CH_CR) begin
						r.kind = close_line();
					end
				end
				chdec_pkg::PH_LF: begin
					phase = chdec_pkg::PH_DATA;
				end
				chdec_pkg::PH_DATA: begin
					r.kind = chdec_pkg::K_BODY;
					r.body_byte = c;
					remaining--;
					if (remaining == 0) begin
						phase = chdec_pkg::PH_TRAIL;
						skip = 2'd2;
					end
				end
				chdec_pkg::PH_TRAIL: begin
					skip--;
					if (skip == 0) begin
						phase = chdec_pkg::PH_SIZE;
						clear_line();
					end
				end
				chdec_pkg::PH_ENDLF: begin
					phase = chdec_pkg::PH_DONE;
					r.kind = chdec_pkg::K_END;
				end
				default: begin
					r.kind = chdec_pkg::K_IGNORE;
				end
			endcase
			case (r.kind)
				chdec_pkg::K_BODY:   n_body++;
				chdec_pkg::K_END:    n_end++;
				chdec_pkg::K_ERROR:  n_err++;
				chdec_pkg::K_IGNORE: n_ignore++;
				default:  ;
			endcase
			due_results.push_back(r);
		endfunction

		function void check_result(logic [2:0] k, logic [7:0] b);
			chdec_pkg::result_t e;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d body %02h", $time, k, b);
				failures++;
				return;
			end
			e = due_results.pop_front();
			checked++;
			if (k !== e.kind) begin
				$display("%0t: kind mismatch, expected %0d, actual %0d", $time, e.kind, k);
				failures++;
			end
			if (b !== e.body_byte) begin
				$display("%0t: body_byte mismatch, expected %02h, actual %02h",
					$time, e.body_byte, b);
				failures++;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	chdec_in_if        in_ch();
	chdec_out_if       out_ch();
	chunk_decode_model model;
	bit                calm_in = 1'b0;
	bit                calm_out = 1'b0;
	bit                start_next = 1'b0;
	int unsigned       bytes_sent = 0;
	int unsigned       messages = 0;
	int unsigned       cycles = 0;

	http_chunked_body_decoder_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, model.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 10) begin
			return 8'("0") + 8'(v);
		end
		return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] ext_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == chdec_pkg::CH_SEMI || c == chdec_pkg::CH_CR);
		return c;
	endfunction

	task automatic drive_byte(input logic [7:0] b, input logic s);
		int unsigned gap;
		gap = pick_gap(calm_in);
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.start_req <= s;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		model.note_byte(b, s);
		bytes_sent++;
	endtask

	task automatic send(input logic [7:0] b);
		drive_byte(b, start_next);
		start_next = 1'b0;
	endtask

	task automatic send_digits(input logic [31:0] value, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			send(hex_char(value[4*i +: 4]));
		end
	endtask

	task automatic send_ext(input int n);
		send(chdec_pkg::CH_SEMI);
		repeat (n) send(ext_char());
	endtask

	task automatic send_size_line(input logic [31:0] value, input int n);
		send_digits(value, n);
		if ($urandom_range(0, 99) < 25) begin
			send_ext($urandom_range(0, 4));
		end
		send(chdec_pkg::CH_CR);
		send(($urandom_range(0, 9) != 0) ? LF_BYTE : 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (model.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_chunk();
		int unsigned r;
		int unsigned sz;
		int          nd;
		r = $urandom_range(0, 99);
		sz = (r < 80) ? $urandom_range(1, 12) : (r < 95) ? $urandom_range(13, 64)
			: $urandom_range(65, 300);
		nd = 1;
		while ((sz >> (4 * nd)) != 0) begin
			nd++;
		end
		nd = nd + $urandom_range(0, 2);
		if (nd > SD) begin
			nd = SD;
		end
		send_size_line(sz, nd);
		repeat (sz) send(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) != 0) begin
			send(chdec_pkg::CH_CR);
			send(LF_BYTE);
		end else begin
			send(8'($urandom_range(0, 255)));
			send(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_bad_line();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: send(chdec_pkg::CH_CR);
			1: send(chdec_pkg::CH_SEMI);
			2: begin
				send_digits($urandom(), $urandom_range(1, 3));
				do begin
					c = 8'($urandom_range(0, 255));
				end while (model.digit_value(c) >= 0 || c == chdec_pkg::CH_SEMI ||
					c == chdec_pkg::CH_CR);
				send(c);
			end
			3: begin
				send_digits($urandom(), $urandom_range(1, 3));
				send_ext($urandom_range(0, 3));
				send(chdec_pkg::CH_SEMI);
			end
			default: begin
				repeat (SD + 1) send(hex_char(4'($urandom_range(0, 15))));
			end
		endcase
	endtask

	task automatic random_message();
		int unsigned r;
		logic [31:0] big;
		start_next = 1'b1;
		repeat ($urandom_range(0, 3)) send_chunk();
		r = $urandom_range(0, 99);
		if (r < 70) begin
			send_size_line(32'd0, $urandom_range(1, 3));
		end else if (r < 85) begin
			send_bad_line();
		end else if (r < 95) begin
			big = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom();
			if (big == 0) begin
				big = 32'd1;
			end
			send_size_line(big, SD);
			repeat ($urandom_range(0, 5)) send(8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 2)) send(8'($urandom_range(0, 255)));
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 8)) begin
			drive_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
		end
	endtask

	initial begin
		int unsigned hold;
		hold = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) begin
				calm_out = !calm_out;
			end
			if (hold != 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				out_ch.ready <= 1'b1;
				hold = pick_gap(calm_out);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			model.check_result(out_ch.kind, out_ch.body_byte);
		end
	end

	initial begin
		model = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.start_req = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extension, full-range body byte, zero-only size, every error form.
		start_next = 1'b1;
		send("1");
		send(chdec_pkg::CH_SEMI);
		send("Z");
		send(chdec_pkg::CH_CR);
		send(LF_BYTE);
		send(8'hff);
		send(chdec_pkg::CH_CR);
		send(LF_BYTE);
		send("0");
		send("0");
		send(chdec_pkg::CH_CR);
		send(LF_BYTE);
		send(8'h00);
		start_next = 1'b1;
		send(chdec_pkg::CH_SEMI);
		send("x");
		start_next = 1'b1;
		send(chdec_pkg::CH_CR);
		start_next = 1'b1;
		send("g");
		start_next = 1'b1;
		send("1");
		send(chdec_pkg::CH_SEMI);
		send(chdec_pkg::CH_SEMI);
		start_next = 1'b1;
		send("f");
		send("F");
		send("a");
		send("B");
		send("c");
		send("D");
		send("e");
		send("9");
		send("0");
		drain();

		while (bytes_sent < ITEMS) begin
			calm_in = ($urandom_range(0, 99) < 15);
			if ($urandom_range(0, 9) == 0) begin
				noise_burst();
			end else begin
				random_message();
			end
			messages++;
			if (messages % 40 == 0) begin
				drain();
			end
		end
		drain();
		repeat (4) @(posedge clk);

		$display("Sent %0d bytes in %0d random messages or bursts; checked %0d results.",
			bytes_sent, messages, model.checked);
		$display("Results held %0d body bytes, %0d message ends, %0d errors, %0d ignored.",
			model.n_body, model.n_end, model.n_err, model.n_ignore);
		if (model.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, model.pending());
		end
		if (model.failures == 0 && model.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
